/* hdl/tmw_pkg.sv */
// Shared types, constants and the month table for the timestamp minutes and weekday block.
// No dependencies; every other source file imports this package.
`timescale 1ns / 1ps

package tmw_pkg;

    // Input transaction: current and previous timestamp
    typedef struct packed {
        logic [13:0] cur_year;
        logic [3:0]  cur_month;
        logic [4:0]  cur_day;
        logic [4:0]  cur_hour;
        logic [5:0]  cur_minute;
        logic        has_previous;
        logic [13:0] prev_year;
        logic [3:0]  prev_month;
        logic [4:0]  prev_day;
        logic [4:0]  prev_hour;
        logic [5:0]  prev_minute;
    } tmw_stamp_t;

    // Output transaction
    typedef struct packed {
        logic [2:0]  weekday;
        logic [31:0] minutes_elapsed;
    } tmw_result_t;

    // Load enables, one per pipeline stage
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
        logic s6;
    } tmw_en_t;

    // Year is biased by one era so the shifted year never goes negative
    localparam logic [14:0]        YEAR_OFS    = 15'd400;
    // floor(x / 25) = (x * 5243) >> 17 for x below 2^13
    localparam logic [12:0]        RECIP25     = 13'd5243;
    localparam logic [8:0]         YEAR_DAYS   = 9'd365;
    // Epoch shift (719468) plus one era (146097) for the year bias
    localparam logic signed [24:0] DAYS_OFS    = 25'sd865565;
    // 3 aligns 1970-01-01 to Thursday; 7 * 130000 keeps the sum positive
    localparam logic signed [23:0] WEEK_BIAS   = 24'sd910003;
    localparam logic signed [11:0] DAY_MINUTES = 12'sd1440;
    localparam logic [10:0]        HOUR_MINUTES = 11'd60;

    // Days from March 1 to the first of the month: (153 * mo + 2) / 5
    function automatic logic [8:0] month_base(input logic [3:0] m);
        logic [8:0] b;
        case (m)
            4'd0:    b = 9'd275;
            4'd1:    b = 9'd306;
            4'd2:    b = 9'd337;
            4'd3:    b = 9'd0;
            4'd4:    b = 9'd31;
            4'd5:    b = 9'd61;
            4'd6:    b = 9'd92;
            4'd7:    b = 9'd122;
            4'd8:    b = 9'd153;
            4'd9:    b = 9'd184;
            4'd10:   b = 9'd214;
            4'd11:   b = 9'd245;
            4'd12:   b = 9'd275;
            4'd13:   b = 9'd306;
            4'd14:   b = 9'd337;
            default: b = 9'd367;
        endcase
        return b;
    endfunction

endpackage

/* hdl/tmw_stamp_conv.sv */
// Three-stage conversion of one timestamp to a day count and a minute of day.
// Depends on tmw_pkg for the enable struct, constants and month table.
`timescale 1ns / 1ps

module tmw_stamp_conv
    import tmw_pkg::*;
(
    input  logic               clk,
    input  tmw_en_t            en,
    input  logic [13:0]        year,
    input  logic [3:0]         month,
    input  logic [4:0]         day,
    input  logic [4:0]         hour,
    input  logic [5:0]         minute,
    output logic signed [23:0] days,
    output logic [10:0]        mod
);

    logic [14:0]        y1_reg, y1_next;
    logic signed [9:0]  doy1_reg, doy1_next;
    logic [10:0]        mod1_reg, mod1_next;

    logic [14:0]        y2_reg;
    logic signed [9:0]  doy2_reg;
    logic [10:0]        mod2_reg;
    logic [8:0]         q100_reg, q100_next;
    logic [23:0]        y365_reg, y365_next;
    logic [25:0]        q_prod;

    logic signed [23:0] days3_reg, days3_next;
    logic [10:0]        mod3_reg;
    logic signed [24:0] day_sum;

    // Stage 1: shift the year into the March-based year, look up day of year, form minute of day
    always_comb
    begin
        y1_next   = 15'({1'b0, year}) + YEAR_OFS - 15'(month <= 4'd2);
        doy1_next = $signed({1'b0, month_base(month)}) + $signed({5'b0, day}) - 10'sd1;
        mod1_next = 11'(hour) * HOUR_MINUTES + 11'(minute);
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            y1_reg   <= y1_next;
            doy1_reg <= doy1_next;
            mod1_reg <= mod1_next;
        end
    end

    // Stage 2: centuries by reciprocal multiply, whole years of 365 days
    always_comb
    begin
        q_prod    = y1_reg[14:2] * RECIP25;
        q100_next = q_prod[25:17];
        y365_next = y1_reg * YEAR_DAYS;
    end

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            y2_reg   <= y1_reg;
            doy2_reg <= doy1_reg;
            mod2_reg <= mod1_reg;
            q100_reg <= q100_next;
            y365_reg <= y365_next;
        end
    end

    // Stage 3: add leap days and day of year, remove the epoch and era bias
    always_comb
    begin
        day_sum = $signed({1'b0, y365_reg})
                + $signed({12'b0, y2_reg[14:2]})
                - $signed({16'b0, q100_reg})
                + $signed({18'b0, q100_reg[8:2]})
                + 25'(doy2_reg)
                - DAYS_OFS;
        days3_next = day_sum[23:0];
    end

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            days3_reg <= days3_next;
            mod3_reg  <= mod2_reg;
        end
    end

    assign days = days3_reg;
    assign mod  = mod3_reg;

endmodule

/* hdl/tmw_diff_week.sv */
// Two-stage minute difference and weekday from the two day counts.
// Depends on tmw_pkg for the enable struct and constants.
`timescale 1ns / 1ps

module tmw_diff_week
    import tmw_pkg::*;
(
    input  logic               clk,
    input  tmw_en_t            en,
    input  logic signed [23:0] cur_days,
    input  logic [10:0]        cur_mod,
    input  logic signed [23:0] prev_days,
    input  logic [10:0]        prev_mod,
    output logic signed [36:0] diff,
    output logic [2:0]         weekday
);

    logic signed [24:0] dd_reg, dd_next;
    logic signed [11:0] md_reg, md_next;
    logic [5:0]         osum_reg, osum_next;
    logic [23:0]        wk;

    logic signed [36:0] diff_reg, diff_next;
    logic signed [36:0] prod;
    logic [2:0]         wd_reg, wd_next;
    logic [3:0]         fold;

    // Stage 4: day and minute-of-day differences, octal digit sum for mod 7
    always_comb
    begin
        dd_next   = 25'(cur_days) - 25'(prev_days);
        md_next   = $signed({1'b0, cur_mod}) - $signed({1'b0, prev_mod});
        wk        = 24'(cur_days + WEEK_BIAS);
        osum_next = '0;
        for (int i = 0; i < 8; i++)
        begin
            osum_next = osum_next + 6'(wk[3*i +: 3]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s4)
        begin
            dd_reg   <= dd_next;
            md_reg   <= md_next;
            osum_reg <= osum_next;
        end
    end

    // Stage 5: scale days to minutes, finish the weekday residue
    always_comb
    begin
        prod      = dd_reg * DAY_MINUTES;
        diff_next = prod + 37'(md_reg);
        fold      = 4'(osum_reg[5:3]) + 4'(osum_reg[2:0]);
        if (fold >= 4'd7)
        begin
            wd_next = 3'(fold - 4'd7);
        end
        else
        begin
            wd_next = fold[2:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s5)
        begin
            diff_reg <= diff_next;
            wd_reg   <= wd_next;
        end
    end

    assign diff    = diff_reg;
    assign weekday = wd_reg;

endmodule

/* hdl/timestamp_minutes_and_weekday.sv */
// Throughput: one transaction per cycle unless result_stall holds it; six register stages with
// per-stage valid bits, bubbles close up, and a stall on the result side backs up stage by stage.
// Reset: rst_n low clears all valid bits at once; payload registers are not reset.
// Top level: stage control, two timestamp converters, difference stage, clamp.
// Depends on tmw_pkg, tmw_stamp_conv and tmw_diff_week.
`timescale 1ns / 1ps

module timestamp_minutes_and_weekday
    import tmw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        stamp_valid,
    output logic        stamp_stall,
    input  tmw_stamp_t  stamp,
    output logic        result_valid,
    input  logic        result_stall,
    output tmw_result_t result
);

    logic [5:0]         valid_reg;
    logic [5:0]         rdy;
    tmw_en_t            en;
    logic [4:0]         hp_reg;

    logic signed [23:0] cur_days, prev_days;
    logic [10:0]        cur_mod, prev_mod;
    logic signed [36:0] diff;
    logic [2:0]         weekday;

    tmw_result_t        result_reg, result_next;

    // A stage loads when it is empty or the next stage loads
    always_comb
    begin
        rdy[5] = !valid_reg[5] || !result_stall;
        for (int i = 4; i >= 0; i--)
        begin
            rdy[i] = !valid_reg[i] || rdy[i + 1];
        end
        en.s1 = rdy[0];
        en.s2 = rdy[1];
        en.s3 = rdy[2];
        en.s4 = rdy[3];
        en.s5 = rdy[4];
        en.s6 = rdy[5];
    end

    assign stamp_stall = !rdy[0];

    // Advance valid bits with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                valid_reg[0] <= stamp_valid;
            end
            for (int i = 1; i < 6; i++)
            begin
                if (rdy[i])
                begin
                    valid_reg[i] <= valid_reg[i - 1];
                end
            end
        end
    end

    // Carry the previous-timestamp flag alongside
    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            hp_reg[0] <= stamp.has_previous;
        end
        for (int i = 1; i < 5; i++)
        begin
            if (rdy[i])
            begin
                hp_reg[i] <= hp_reg[i - 1];
            end
        end
    end

    tmw_stamp_conv u_cur (
        .clk    (clk),
        .en     (en),
        .year   (stamp.cur_year),
        .month  (stamp.cur_month),
        .day    (stamp.cur_day),
        .hour   (stamp.cur_hour),
        .minute (stamp.cur_minute),
        .days   (cur_days),
        .mod    (cur_mod)
    );

    tmw_stamp_conv u_prev (
        .clk    (clk),
        .en     (en),
        .year   (stamp.prev_year),
        .month  (stamp.prev_month),
        .day    (stamp.prev_day),
        .hour   (stamp.prev_hour),
        .minute (stamp.prev_minute),
        .days   (prev_days),
        .mod    (prev_mod)
    );

    tmw_diff_week u_diff (
        .clk       (clk),
        .en        (en),
        .cur_days  (cur_days),
        .cur_mod   (cur_mod),
        .prev_days (prev_days),
        .prev_mod  (prev_mod),
        .diff      (diff),
        .weekday   (weekday)
    );

    // Stage 6: clamp the difference to the 32-bit range, drop it without a previous stamp
    always_comb
    begin
        result_next.weekday = weekday;
        if (!hp_reg[4] || diff[36])
        begin
            result_next.minutes_elapsed = '0;
        end
        else if (diff[35:32] != 4'd0)
        begin
            result_next.minutes_elapsed = '1;
        end
        else
        begin
            result_next.minutes_elapsed = diff[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s6)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = valid_reg[5];
    assign result       = result_reg;

endmodule

/* hdl/tmw_checker.sv */
// Port-level checker for timestamp_minutes_and_weekday, bound to the top level.
// Depends on tmw_pkg for the transaction types.
`timescale 1ns / 1ps

module tmw_checker
    import tmw_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        stamp_stall,
    input logic        result_valid,
    input logic        result_stall,
    input tmw_result_t result
);

    // Hold a stalled result transaction
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result transaction changed or dropped");

    // Stall the input only when the whole pipeline is backed up
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        stamp_stall |-> result_valid && result_stall)
        else $error("input stalled while the result side is free");

    // Keep the weekday within Monday through Sunday
    a_weekday_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.weekday <= 3'd6)
        else $error("weekday out of range");

    // Show no result once a reset cycle has been seen
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !result_valid)
        else $error("result valid during reset");

endmodule

bind timestamp_minutes_and_weekday tmw_checker u_tmw_checker (.*);

/* tb/tb_timestamp_minutes_and_weekday.sv */
// Testbench for timestamp_minutes_and_weekday: predicts weekday and elapsed minutes per
// transaction and checks every result in order. Depends on tmw_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_timestamp_minutes_and_weekday;
    import tmw_pkg::*;

    localparam longint ERA_LEN_DAYS    = 146097;
    localparam longint EPOCH_DAY_SHIFT = 719468;
    localparam longint MINUTES_PER_DAY = 1440;
    localparam longint MINUTES_CEILING = 64'h0000_0000_ffff_ffff;
    localparam int     DRAIN_CYCLES    = 20;
    localparam longint TIMEOUT_NS      = 5_000_000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        stamp_valid = 1'b0;
    logic        stamp_stall;
    tmw_stamp_t  stamp = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    tmw_result_t result;

    tmw_result_t expected_results[$];
    int          error_count = 0;
    bit          idling_on = 1'b1;
    bit          idling_locked = 1'b0;
    int          stall_left = 0;

    timestamp_minutes_and_weekday dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .stamp_valid  (stamp_valid),
        .stamp_stall  (stamp_stall),
        .stamp        (stamp),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Day count since 1970-01-01 with 400-year eras and a March-based year
    function automatic longint civil_day_number(input longint year, input longint month,
                                                input longint day);
        longint y;
        longint era;
        longint yoe;
        longint mo;
        longint doy;
        longint doe;
        y = year;
        if (month <= 2)
            y = y - 1;
        era = (y >= 0 ? y : y - 399) / 400;
        yoe = y - era * 400;
        mo = (month > 2) ? month - 3 : month + 9;
        doy = (153 * mo + 2) / 5 + day - 1;
        doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        return era * ERA_LEN_DAYS + doe - EPOCH_DAY_SHIFT;
    endfunction

    function automatic longint stamp_in_minutes(input longint year, input longint month,
                                                input longint day, input longint hour,
                                                input longint minute);
        return civil_day_number(year, month, day) * MINUTES_PER_DAY + hour * 60 + minute;
    endfunction

    function automatic tmw_result_t predict_weekday_and_minutes(input tmw_stamp_t s);
        tmw_result_t r;
        longint days;
        longint wd;
        longint diff;
        days = civil_day_number(s.cur_year, s.cur_month, s.cur_day);
        wd = (days + 3) % 7;
        if (wd < 0)
            wd = wd + 7;
        diff = 0;
        if (s.has_previous)
        begin
            diff = stamp_in_minutes(s.cur_year, s.cur_month, s.cur_day, s.cur_hour,
                                    s.cur_minute)
                 - stamp_in_minutes(s.prev_year, s.prev_month, s.prev_day, s.prev_hour,
                                    s.prev_minute);
            if (diff < 0)
                diff = 0;
            if (diff > MINUTES_CEILING)
                diff = MINUTES_CEILING;
        end
        r.weekday = wd[2:0];
        r.minutes_elapsed = diff[31:0];
        return r;
    endfunction

    function automatic tmw_stamp_t make_stamp(input int cy, input int cm, input int cd,
                                              input int ch, input int cn, input bit hp,
                                              input int py, input int pm, input int pd,
                                              input int ph, input int pn);
        tmw_stamp_t s;
        s.cur_year     = cy[13:0];
        s.cur_month    = cm[3:0];
        s.cur_day      = cd[4:0];
        s.cur_hour     = ch[4:0];
        s.cur_minute   = cn[5:0];
        s.has_previous = hp;
        s.prev_year    = py[13:0];
        s.prev_month   = pm[3:0];
        s.prev_day     = pd[4:0];
        s.prev_hour    = ph[4:0];
        s.prev_minute  = pn[5:0];
        return s;
    endfunction

    // Offer one transaction, with an optional idle burst first; queue its prediction
    task automatic send_stamp(input tmw_stamp_t s);
        int gap;
        if (idling_on && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 13);
            stamp_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        stamp_valid <= 1'b1;
        stamp <= s;
        @(posedge clk);
        while (stamp_stall)
            @(posedge clk);
        expected_results.push_back(predict_weekday_and_minutes(s));
    endtask

    task automatic wait_until_drained();
        stamp_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // Epoch, leap rules, large years, and out-of-range day, hour and minute
    task automatic test_calendar_basics();
        send_stamp(make_stamp(1970, 1, 1, 0, 0, 1'b0, 0, 0, 0, 0, 0));
        send_stamp(make_stamp(1970, 1, 1, 0, 1, 1'b1, 1970, 1, 1, 0, 0));
        send_stamp(make_stamp(2000, 3, 1, 0, 0, 1'b1, 2000, 2, 28, 0, 0));
        send_stamp(make_stamp(1900, 3, 1, 0, 0, 1'b1, 1900, 2, 28, 0, 0));
        send_stamp(make_stamp(2024, 3, 0, 24, 60, 1'b1, 2024, 2, 29, 0, 0));
        send_stamp(make_stamp(12000, 6, 15, 12, 30, 1'b1, 11999, 12, 31, 23, 59));
        send_stamp(make_stamp(9999, 12, 31, 23, 59, 1'b1, 0, 1, 1, 0, 0));
    endtask

    // No previous stamp, previous after current, saturation, all-zero and all-one fields
    task automatic test_previous_special_cases();
        send_stamp(make_stamp(0, 0, 0, 0, 0, 1'b1, 0, 0, 0, 0, 0));
        send_stamp(make_stamp(16383, 15, 31, 31, 63, 1'b1, 0, 0, 0, 0, 0));
        send_stamp(make_stamp(0, 0, 0, 0, 0, 1'b1, 16383, 15, 31, 31, 63));
        send_stamp(make_stamp(16383, 15, 31, 31, 63, 1'b0, 16383, 15, 31, 31, 63));
        send_stamp(make_stamp(2023, 5, 10, 8, 0, 1'b1, 2023, 5, 10, 8, 1));
    endtask

    // Walk every month code, including 0 and 13 to 15
    task automatic test_month_offsets();
        int m;
        for (m = 0; m < 16; m++)
            send_stamp(make_stamp(2000, m, 15, 6, 7, 1'b1, 1999, m, 14, 18, 45));
    endtask

    // Mostly calendar-valid pairs near each other, the rest raw bits
    task automatic test_random_stamps(input int count);
        tmw_stamp_t s;
        logic [95:0] raw;
        int k;
        for (k = 0; k < count; k++)
        begin
            if (k % 60 == 0 && !idling_locked)
                idling_on = ($urandom_range(0, 3) != 0);
            raw = {$urandom, $urandom, $urandom};
            s = raw[$bits(tmw_stamp_t)-1:0];
            if ($urandom_range(0, 9) < 7)
            begin
                s.cur_year     = 14'($urandom_range(0, 9999));
                s.cur_month    = 4'($urandom_range(1, 12));
                s.cur_day      = 5'($urandom_range(1, 28));
                s.cur_hour     = 5'($urandom_range(0, 23));
                s.cur_minute   = 6'($urandom_range(0, 59));
                s.has_previous = ($urandom_range(0, 7) != 0);
                s.prev_year    = 14'($urandom_range(0, 9999));
                s.prev_month   = 4'($urandom_range(1, 12));
                s.prev_day     = 5'($urandom_range(1, 28));
                s.prev_hour    = 5'($urandom_range(0, 23));
                s.prev_minute  = 6'($urandom_range(0, 59));
                case ($urandom_range(0, 2))
                    0:
                    begin
                        // keep the independent previous stamp
                    end
                    1:
                    begin
                        s.prev_year = (s.cur_year > 14'd1)
                                    ? 14'(s.cur_year - 14'($urandom_range(0, 1)))
                                    : s.cur_year;
                    end
                    default:
                    begin
                        s.prev_year  = s.cur_year;
                        s.prev_month = s.cur_month;
                        s.prev_day   = s.cur_day;
                    end
                endcase
            end
            send_stamp(s);
        end
    endtask

    // Hold the sender until every queued result has come back, then resume
    task automatic test_drain_pause();
        test_random_stamps(40);
        wait_until_drained();
        repeat ($urandom_range(1, 5)) @(posedge clk);
        test_random_stamps(40);
    endtask

    task automatic test_back_to_back();
        idling_locked = 1'b1;
        idling_on = 1'b0;
        test_random_stamps(1);
        idling_on = 1'b0;
        test_previous_special_cases();
        test_random_stamps(60);
    endtask

    // Drive result_stall in random bursts
    always @(posedge clk)
    begin
        if (!idling_on)
        begin
            result_stall <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            result_stall <= 1'b1;
            stall_left <= $urandom_range(0, 12);
        end
        else
        begin
            result_stall <= 1'b0;
        end
    end

    // Compare each accepted result against the oldest prediction
    always @(posedge clk)
    begin : check_results
        tmw_result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got weekday %0d minutes %0d",
                         $time, result.weekday, result.minutes_elapsed);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (result.weekday !== want.weekday)
                begin
                    $display("%0t: weekday mismatch, expected %0d, got %0d",
                             $time, want.weekday, result.weekday);
                    error_count++;
                end
                if (result.minutes_elapsed !== want.minutes_elapsed)
                begin
                    $display("%0t: minutes_elapsed mismatch, expected %0d, got %0d",
                             $time, want.minutes_elapsed, result.minutes_elapsed);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_calendar_basics();
        test_previous_special_cases();
        test_month_offsets();
        test_random_stamps(380);
        test_drain_pause();
        test_random_stamps(340);
        test_back_to_back();
        wait_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("tb_timestamp_minutes_and_weekday passed");
        else
            $display("tb_timestamp_minutes_and_weekday failed");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #(TIMEOUT_NS);
        $display("tb_timestamp_minutes_and_weekday failed");
        $finish;
    end

endmodule

/* filelist.f */
hdl/tmw_pkg.sv
hdl/tmw_stamp_conv.sv
hdl/tmw_diff_week.sv
hdl/timestamp_minutes_and_weekday.sv
hdl/tmw_checker.sv
tb/tb_timestamp_minutes_and_weekday.sv
